### hw/rtl/frequency_shift_metal_detector_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef FREQUENCY_SHIFT_METAL_DETECTOR_MACROS_SVH
`define FREQUENCY_SHIFT_METAL_DETECTOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define FSMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsmd check failed");
// Next-cycle implication, checked outside reset.
`define FSMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsmd check failed");
`else
`define FSMD_ASSERT_NOW(label, ante, cons)
`define FSMD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/fsmd_pkg.sv
package fsmd_pkg;

    localparam int WINDOW_LEN_DEF = 10;
    localparam int FREQ_BITS_DEF  = 24;

    localparam int NUM_W     = 32;
    localparam int CNT_W     = 41;
    localparam int BP_W      = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [NUM_W-1:0] NUM_RESET     = 32'd3200000000;
    localparam logic [BP_W-1:0]  DETECT_RESET  = 14'd80;
    localparam logic [BP_W-1:0]  RELEASE_RESET = 14'd2;

    // Deviations are compared in basis points.
    localparam logic [BP_W-1:0]  BP_SCALE = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;

endpackage

### hw/rtl/fsmd_ram.sv
module fsmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/frequency_shift_metal_detector.sv
// Coin detector on the frequency of a search-coil oscillator.
// Input channel (i_valid / o_ready) takes one period count per item; a
// count of zero means no signal and leaves all state untouched. Output
// channel (o_valid / i_ready) gives one result per item: frequency, moving
// average over WINDOW_LEN samples, baseline and the coin flag and event.
// A nonzero count is divided into the numerator by a radix-2 restoring
// divider, the sample replaces the oldest slot of the window memory, and
// the window sum is divided by WINDOW_LEN through a multiply by its
// reciprocal. The states ST_DEV, ST_MUL, ST_DECIDE and ST_OUT then form
// the deviation, the products, the decision and the output load. One item
// is in work at a time; the next is accepted once the result has moved
// into the output register.
// The output register holds a result while the receiver stalls; a
// finished item waits in its last state until that register is free.
// Reset is synchronous; it restores the configuration defaults, empties
// the window through per-slot valid bits and clears baseline and flag.
module frequency_shift_metal_detector
    import fsmd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int FREQ_BITS  = FREQ_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CNT_W-1:0]     i_period_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_signal_valid,
    output logic [FREQ_BITS-1:0] o_frequency_hz,
    output logic [FREQ_BITS-1:0] o_average_hz,
    output logic [FREQ_BITS-1:0] o_baseline_hz,
    output logic                 o_coin_present,
    output logic                 o_coin_event
);

    `include "frequency_shift_metal_detector_macros.svh"

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = FREQ_BITS + $clog2(WINDOW_LEN);
    localparam int DVD_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int ITER_W = $clog2(DVD_W + 1);
    localparam int PROD_W = FREQ_BITS + BP_W;
    localparam logic [NUM_W-1:0] FREQ_MAX_Q =
        NUM_W'((64'd1 << FREQ_BITS) - 64'd1);
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};

    // The reciprocal is rounded up with enough fraction bits that the
    // product gives the exact floor for every reachable window sum.
    localparam int RCP_SH     = SUM_W + SLOT_W;
    localparam int RCP_W      = SUM_W + 1;
    localparam int AVG_PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVF,
        ST_UPDATE,
        ST_AVG_LD,
        ST_DEV,
        ST_MUL,
        ST_DECIDE,
        ST_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [NUM_W-1:0] r_num;
    logic [BP_W-1:0]  r_det;
    logic [BP_W-1:0]  r_rel;

    // Block state outside the window memory
    logic [SLOT_W-1:0]     r_slot;
    logic [WINDOW_LEN-1:0] r_slot_vld;
    logic [SUM_W-1:0]      r_sum;
    logic [FREQ_BITS-1:0]  r_avg;
    logic [FREQ_BITS-1:0]  r_base;
    logic                  r_flag;

    // Per-item working registers
    logic                  r_nz;
    logic                  r_event;
    logic [FREQ_BITS-1:0]  r_freq;
    logic [AVG_PROD_W-1:0] r_avg_prod;
    logic [FREQ_BITS-1:0]  r_dev;
    logic [PROD_W-1:0]     r_sdev;
    logic [PROD_W-1:0]     r_dthr;
    logic [PROD_W-1:0]     r_rthr;

    // Restoring divider for the frequency
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [ITER_W-1:0] r_iter;

    // Output register
    logic                 r_ov;
    logic                 r_o_sv;
    logic [FREQ_BITS-1:0] r_o_freq;
    logic [FREQ_BITS-1:0] r_o_avg;
    logic [FREQ_BITS-1:0] r_o_base;
    logic                 r_o_flag;
    logic                 r_o_event;

    logic                 in_acc;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_diff;
    logic                 rem_ge;
    logic [NUM_W-1:0]     quot;
    logic [FREQ_BITS-1:0] n_freq;
    logic [FREQ_BITS-1:0] old_freq;
    logic [FREQ_BITS-1:0] ram_rdata;
    logic [SUM_W-1:0]     n_sum;
    logic [FREQ_BITS-1:0] avg_q;
    logic [FREQ_BITS-1:0] n_base;
    logic                 out_free;
    logic                 out_load;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    // One quotient bit per cycle; the remainder always stays below the divisor.
    assign rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign rem_ge   = (rem_sh >= {1'b0, r_dvs});

    assign quot   = r_dvd[NUM_W-1:0];
    assign n_freq = (quot > FREQ_MAX_Q) ? FREQ_MAX : quot[FREQ_BITS-1:0];

    // A slot never written since reset counts as zero.
    assign old_freq = r_slot_vld[r_slot] ? ram_rdata : '0;
    assign n_sum    = r_sum - SUM_W'(old_freq) + SUM_W'(n_freq);

    assign avg_q  = r_avg_prod[RCP_SH +: FREQ_BITS];
    assign n_base = (r_base == '0) ? avg_q : r_base;

    assign out_free = !r_ov || i_ready;
    assign out_load = (r_state == ST_OUT) && out_free;

    // The slot is read at acceptance and written in ST_UPDATE of the same
    // item; the next read only happens after that write, so no forwarding.
    fsmd_ram #(
        .WIDTH(FREQ_BITS),
        .DEPTH(WINDOW_LEN)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_UPDATE),
        .i_waddr(r_slot),
        .i_wdata(n_freq),
        .i_re   (in_acc),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_num      <= NUM_RESET;
            r_det      <= DETECT_RESET;
            r_rel      <= RELEASE_RESET;
            r_slot     <= '0;
            r_slot_vld <= '0;
            r_sum      <= '0;
            r_avg      <= '0;
            r_base     <= '0;
            r_flag     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUMERATOR: r_num <= i_cfg_data[NUM_W-1:0];
                    CFG_DETECT:    r_det <= i_cfg_data[BP_W-1:0];
                    CFG_RELEASE:   r_rel <= i_cfg_data[BP_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_event <= 1'b0;
                        if (i_period_count == '0) begin
                            r_nz    <= 1'b0;
                            r_freq  <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_nz    <= 1'b1;
                            r_dvd   <= DVD_W'(r_num) << (DVD_W - NUM_W);
                            r_rem   <= '0;
                            r_dvs   <= i_period_count;
                            r_iter  <= ITER_W'(NUM_W);
                            r_state <= ST_DIVF;
                        end
                    end
                end
                ST_DIVF: begin
                    r_rem  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    r_dvd  <= {r_dvd[DVD_W-2:0], rem_ge};
                    r_iter <= r_iter - 1'b1;
                    if (r_iter == ITER_W'(1)) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_freq             <= n_freq;
                    r_sum              <= n_sum;
                    r_slot_vld[r_slot] <= 1'b1;
                    r_slot  <= (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                    r_state <= ST_AVG_LD;
                end
                ST_AVG_LD: begin
                    r_avg_prod <= AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_RCP);
                    r_state    <= ST_DEV;
                end
                ST_DEV: begin
                    r_avg   <= avg_q;
                    r_base  <= n_base;
                    r_dev   <= (avg_q >= n_base) ? avg_q - n_base : n_base - avg_q;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_sdev  <= PROD_W'(r_dev) * PROD_W'(BP_SCALE);
                    r_dthr  <= PROD_W'(r_det) * PROD_W'(r_base);
                    r_rthr  <= PROD_W'(r_rel) * PROD_W'(r_base);
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (!r_flag && (r_sdev > r_dthr)) begin
                        r_flag  <= 1'b1;
                        r_event <= 1'b1;
                        r_base  <= r_avg;
                    end else if (r_flag && (r_sdev < r_rthr)) begin
                        r_flag <= 1'b0;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_sv    <= r_nz;
                        r_o_freq  <= r_freq;
                        r_o_avg   <= r_avg;
                        r_o_base  <= r_base;
                        r_o_flag  <= r_flag;
                        r_o_event <= r_event;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_signal_valid = r_o_sv;
    assign o_frequency_hz = r_o_freq;
    assign o_average_hz   = r_o_avg;
    assign o_baseline_hz  = r_o_base;
    assign o_coin_present = r_o_flag;
    assign o_coin_event   = r_o_event;

    `FSMD_ASSERT_NOW(a_event_sets_flag, o_valid && o_coin_event, o_coin_present)
    `FSMD_ASSERT_NOW(a_no_signal_result, o_valid && !o_signal_valid,
        (o_frequency_hz == '0) && !o_coin_event)
    `FSMD_ASSERT_NEXT(a_zero_count_skips, in_acc && (i_period_count == '0),
        r_state == ST_OUT)
    `FSMD_ASSERT_NEXT(a_update_marks_slot, r_state == ST_UPDATE,
        (r_slot_vld[$past(r_slot)] == 1'b1) && (r_state == ST_AVG_LD))

endmodule

### tb/frequency_shift_metal_detector_tb.sv
module frequency_shift_metal_detector_tb;
    import fsmd_pkg::*;

    localparam int WINDOW = WINDOW_LEN_DEF;
    localparam longint unsigned FREQ_CEIL = (64'd1 << FREQ_BITS_DEF) - 1;
    localparam int DIRECTED_N = 25;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic                     has_signal;
        logic [FREQ_BITS_DEF-1:0] freq_hz;
        logic [FREQ_BITS_DEF-1:0] avg_hz;
        logic [FREQ_BITS_DEF-1:0] base_hz;
        logic                     present;
        logic                     coin_evt;
    } detector_result_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             typed;
        detector_result_t want;
    } directed_row_t;

    localparam detector_result_t NO_READING = '0;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CNT_W-1:0]     i_period_count = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_signal_valid;
    logic [FREQ_BITS_DEF-1:0] o_frequency_hz;
    logic [FREQ_BITS_DEF-1:0] o_average_hz;
    logic [FREQ_BITS_DEF-1:0] o_baseline_hz;
    logic                 o_coin_present;
    logic                 o_coin_event;

    frequency_shift_metal_detector u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_period_count (i_period_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_signal_valid (o_signal_valid),
        .o_frequency_hz (o_frequency_hz),
        .o_average_hz   (o_average_hz),
        .o_baseline_hz  (o_baseline_hz),
        .o_coin_present (o_coin_present),
        .o_coin_event   (o_coin_event)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the detector state and its registers.
    longint unsigned cfg_numerator;
    longint unsigned cfg_detect_bp;
    longint unsigned cfg_release_bp;
    longint unsigned win_freq [WINDOW];
    int              win_slot;
    longint unsigned win_total;
    longint unsigned cur_baseline;
    logic            coin_latched;

    detector_result_t queued_readings [$];

    int mismatches = 0;
    int items_sent = 0;
    int silent_items = 0;
    int readings_checked = 0;
    int detections = 0;
    int releases = 0;
    int settings_used = 1;
    int burst_left = 0;

    function automatic detector_result_t predict_detection(input logic [CNT_W-1:0] count);
        detector_result_t r;
        longint unsigned num64, cnt64, f, a, dev, scaled;
        r = NO_READING;
        if (count != 0) begin
            num64 = cfg_numerator;
            cnt64 = 64'(count);
            f = num64 / cnt64;
            if (f > FREQ_CEIL)
                f = FREQ_CEIL;
            if (win_slot >= WINDOW)
                win_slot = 0;
            win_total = win_total - win_freq[win_slot] + f;
            win_freq[win_slot] = f;
            win_slot = (win_slot + 1 >= WINDOW) ? 0 : win_slot + 1;
            a = win_total / WINDOW;
            if (cur_baseline == 0)
                cur_baseline = a;
            dev = (a >= cur_baseline) ? a - cur_baseline : cur_baseline - a;
            scaled = dev * BP_SCALE;
            if (!coin_latched && scaled > cfg_detect_bp * cur_baseline) begin
                coin_latched = 1'b1;
                r.coin_evt = 1'b1;
                cur_baseline = a;
                detections++;
            end else if (coin_latched && scaled < cfg_release_bp * cur_baseline) begin
                coin_latched = 1'b0;
                releases++;
            end
            r.has_signal = 1'b1;
            r.freq_hz = f[FREQ_BITS_DEF-1:0];
        end
        a = win_total / WINDOW;
        r.avg_hz = a[FREQ_BITS_DEF-1:0];
        r.base_hz = cur_baseline[FREQ_BITS_DEF-1:0];
        r.present = coin_latched;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < 30)
            $display("MISMATCH result %0d %s: got %h expected %h",
                     readings_checked, what, got, want);
        mismatches++;
    endtask

    // Offers one item, then keeps or drops valid depending on the burst.
    task automatic offer_count(input logic [CNT_W-1:0] count, input logic typed,
                               input detector_result_t typed_want);
        detector_result_t predicted;
        int gap;
        i_valid <= 1'b1;
        i_period_count <= count;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_detection(count);
        queued_readings.push_back(typed ? typed_want : predicted);
        items_sent++;
        if (count == 0)
            silent_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_readings();
        i_valid <= 1'b0;
        while (queued_readings.size() != 0)
            @(posedge i_clk);
    endtask

    // Registers are written back to back; the detect and release words carry
    // random upper bits that the block must ignore.
    task automatic apply_settings(input logic [NUM_W-1:0] num, input logic [BP_W-1:0] det,
                                  input logic [BP_W-1:0] rel);
        logic [CFG_W-1:0] word;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_NUMERATOR;
        i_cfg_data <= num;
        @(posedge i_clk);
        cfg_numerator = 64'(num);
        word = $urandom;
        word[BP_W-1:0] = det;
        i_cfg_idx <= CFG_DETECT;
        i_cfg_data <= word;
        @(posedge i_clk);
        cfg_detect_bp = 64'(det);
        word = $urandom;
        word[BP_W-1:0] = rel;
        i_cfg_idx <= CFG_RELEASE;
        i_cfg_data <= word;
        @(posedge i_clk);
        cfg_release_bp = 64'(rel);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        detector_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (queued_readings.size() == 0) begin
                flag_mismatch("result with none outstanding", 64'(o_frequency_hz), 64'd0);
            end else begin
                want = queued_readings.pop_front();
                if (o_signal_valid !== want.has_signal)
                    flag_mismatch("signal_valid", 64'(o_signal_valid), 64'(want.has_signal));
                if (o_frequency_hz !== want.freq_hz)
                    flag_mismatch("frequency_hz", 64'(o_frequency_hz), 64'(want.freq_hz));
                if (o_average_hz !== want.avg_hz)
                    flag_mismatch("average_hz", 64'(o_average_hz), 64'(want.avg_hz));
                if (o_baseline_hz !== want.base_hz)
                    flag_mismatch("baseline_hz", 64'(o_baseline_hz), 64'(want.base_hz));
                if (o_coin_present !== want.present)
                    flag_mismatch("coin_present", 64'(o_coin_present), 64'(want.present));
                if (o_coin_event !== want.coin_evt)
                    flag_mismatch("coin_event", 64'(o_coin_event), 64'(want.coin_evt));
            end
            readings_checked++;
        end
    end

    // Receiver: rotating stall patterns, plus two long hold-offs that let the
    // block fill up and push back on its input.
    int rx_cycle = 0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if ((rx_cycle >= 3000 && rx_cycle < 3600) || (rx_cycle >= 40000 && rx_cycle < 40600))
            i_ready <= 1'b0;
        else begin
            case (rx_cycle[9:8])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= 1'($urandom_range(0, 1));
                2'd2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= rx_cycle[3];
            endcase
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("** frequency_shift_metal_detector: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        directed_row_t    directed_rows [DIRECTED_N];
        logic [NUM_W-1:0] set_num [PHASES];
        logic [BP_W-1:0]  set_det [PHASES];
        logic [BP_W-1:0]  set_rel [PHASES];
        longint unsigned  base, shifted, c, pct;
        logic [63:0]      wide;
        logic [CNT_W-1:0] count;
        logic             in_shift;
        int               run_left;

        cfg_numerator = 64'(NUM_RESET);
        cfg_detect_bp = 64'(DETECT_RESET);
        cfg_release_bp = 64'(RELEASE_RESET);
        for (int i = 0; i < WINDOW; i++)
            win_freq[i] = 0;
        win_slot = 0;
        win_total = 0;
        cur_baseline = 0;
        coin_latched = 1'b0;

        // Typed rows: empty state, a count too large for any frequency, and a
        // count of one that saturates and seeds the baseline.
        directed_rows = '{
            {41'd0, 1'b1, NO_READING},
            {COUNT_MAX, 1'b1, {1'b1, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0}},
            {41'd1, 1'b1, {1'b1, 24'd16777215, 24'd1677721, 24'd1677721, 1'b0, 1'b0}},
            {41'd0, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd3200000000, 1'b0, NO_READING},
            {41'd3200000001, 1'b0, NO_READING},
            {41'd40000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd32000, 1'b0, NO_READING},
            {41'd2, 1'b0, NO_READING},
            {41'd0, 1'b0, NO_READING},
            {41'd64000, 1'b0, NO_READING},
            {41'd64000, 1'b0, NO_READING},
            {41'd64000, 1'b0, NO_READING},
            {41'd4294967295, 1'b0, NO_READING},
            {41'h10000000000, 1'b0, NO_READING}
        };

        set_num[0] = NUM_RESET;      set_det[0] = 14'd80;    set_rel[0] = 14'd30;
        set_num[1] = 32'hFFFFFFFF;   set_det[1] = 14'd0;     set_rel[1] = 14'd0;
        set_num[2] = 32'd1;          set_det[2] = 14'h3FFF;  set_rel[2] = 14'h3FFF;
        set_num[3] = 32'd0;          set_det[3] = DETECT_RESET; set_rel[3] = RELEASE_RESET;
        for (int p = 4; p < PHASES; p++) begin
            set_num[p] = $urandom_range(32'd1000000, 32'hFFFFFFFF);
            set_det[p] = 14'($urandom_range(0, 400));
            set_rel[p] = 14'($urandom_range(0, set_det[p]));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_N; r++)
            offer_count(directed_rows[r].count, directed_rows[r].typed, directed_rows[r].want);

        for (int p = 0; p < PHASES; p++) begin
            wait_for_readings();
            repeat (4) @(posedge i_clk);
            apply_settings(set_num[p], set_det[p], set_rel[p]);
            settings_used++;

            if (cfg_numerator >= 2000000)
                base = cfg_numerator / 64'($urandom_range(1000, 2000000));
            else
                base = 64'($urandom_range(1, 4));
            shifted = base;
            in_shift = 1'b0;
            run_left = $urandom_range(10, 25);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Steady stretches alternate with shifted ones, as a coin
                // passing over the coil would cause.
                if (run_left == 0) begin
                    in_shift = !in_shift;
                    run_left = $urandom_range(8, 25);
                    if (in_shift) begin
                        pct = 64'($urandom_range(1, 60));
                        shifted = $urandom_range(0, 1) ? base + base * pct / 1000
                                                       : base - base * pct / 1000;
                        if (shifted == 0)
                            shifted = 1;
                    end
                end
                run_left--;
                case ($urandom_range(0, 19))
                    0: count = '0;
                    1: begin
                        wide = {$urandom, $urandom};
                        count = wide[CNT_W-1:0] >> $urandom_range(0, CNT_W - 1);
                    end
                    default: begin
                        c = in_shift ? shifted : base;
                        if ($urandom_range(0, 3) == 0)
                            c = $urandom_range(0, 1) ? c + 1 : ((c > 1) ? c - 1 : c);
                        count = c[CNT_W-1:0];
                    end
                endcase
                offer_count(count, 1'b0, NO_READING);
            end
        end

        wait_for_readings();
        repeat (100) @(posedge i_clk);
        if (queued_readings.size() != 0)
            flag_mismatch("results never delivered", 64'(queued_readings.size()), 64'd0);

        $display("Run covered %0d items (%0d without signal) under %0d register settings.",
                 items_sent, silent_items, settings_used);
        $display("%0d results checked; %0d coin detections and %0d flag releases predicted.",
                 readings_checked, detections, releases);
        if (mismatches == 0)
            $display("** frequency_shift_metal_detector: PASSED **");
        else
            $display("** frequency_shift_metal_detector: FAILED **");
        $finish;
    end

endmodule
